// ===== src/bba_pkg.sv =====
package bba_pkg;

    // store geometry
    localparam int NUM_BLOCKS = 1024;
    localparam int WORD_BITS  = 32;
    localparam int NUM_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W      = $clog2(WORD_BITS);

    // field widths
    localparam int BLK_W = 10;
    localparam int ST_W  = 2;

    typedef logic [BLK_W-1:0]     blk_t;
    typedef logic [ST_W-1:0]      status_t;
    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [WORD_AW-1:0]   waddr_t;
    typedef logic [BIT_W-1:0]     bitpos_t;

    // status codes
    localparam status_t ST_OK            = 2'd0;
    localparam status_t ST_OUT_OF_BLOCKS = 2'd1;
    localparam status_t ST_DOUBLE_FREE   = 2'd2;
    localparam status_t ST_OUT_OF_RANGE  = 2'd3;

    // request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam blk_t FDB_RESET = 10'd8;

    // lowest set bit of a word: priority encoder
    function automatic bitpos_t lowest_one(input word_t vec);
        bitpos_t pos;
        pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (vec[b])
            begin
                pos = BIT_W'(b);
            end
        end
        return pos;
    endfunction

endpackage

// ===== src/bba_ram.sv =====
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/bitmap_block_allocator.sv =====
// Bitmap first-fit block allocator.
// Requests arrive on the in_valid/in_ready channel: op selects allocate or
// free, block_index names the block to free. Each request gives exactly one
// result beat on out_valid/out_ready: block_number and status.
// The usage bitmap lives in a one-port-read, one-port-write RAM of 32-bit
// words. An allocate reads one word per cycle upward from the word that holds
// first_data_block until it finds a free, allowed block or has read the last
// word, up to 32 words in all. A free is one read-modify-write of the word
// that holds block_index.
// One request is in flight at a time; the next is accepted the cycle after
// the result is loaded into the output register, while that result may wait.
// Reset clears the per-word valid flags, so every block reads as free at
// once, and first_data_block returns to 8. cfg_we writes first_data_block
// and should only be used while the block is idle.
// If the receiver stalls, the finished result holds in the output register
// and a following result waits in the block, which then accepts nothing.
module bitmap_block_allocator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  bba_pkg::blk_t     cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              op,
    input  bba_pkg::blk_t     block_index,
    output logic              out_valid,
    input  logic              out_ready,
    output bba_pkg::blk_t     block_number,
    output bba_pkg::status_t  status
);

    import bba_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FREE = 2'd2;
    localparam logic [1:0] S_PUB  = 2'd3;

    logic [1:0]            state_reg, state_next;
    blk_t                  fdb_reg;
    waddr_t                chk_addr_reg, chk_addr_next;
    bitpos_t               idx_bit_reg, idx_bit_next;
    blk_t                  res_num_reg, res_num_next;
    status_t               res_st_reg, res_st_next;
    logic                  out_valid_reg;
    blk_t                  out_num_reg;
    status_t               out_st_reg;
    logic [NUM_WORDS-1:0]  valid_reg;

    waddr_t                rd_addr;
    word_t                 rd_data;
    logic                  ram_we;
    word_t                 ram_wdata;
    word_t                 eff_word;
    word_t                 allowed;
    word_t                 free_vec;
    logic                  hit;
    bitpos_t               hit_pos;
    word_t                 hit_bit;
    word_t                 free_bit;
    logic                  accept;
    logic                  slot_free;
    logic                  fdb_beyond;
    logic                  idx_beyond;

    // bitmap store
    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (chk_addr_reg),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign in_ready     = (state_reg == S_IDLE);
    assign accept       = in_valid && in_ready;
    assign slot_free    = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign block_number = out_num_reg;
    assign status       = out_st_reg;

    assign fdb_beyond = (32'(fdb_reg) >= NUM_BLOCKS);
    assign idx_beyond = (32'(block_index) >= NUM_BLOCKS);

    // word under test: a never-written word reads as all free
    assign eff_word = valid_reg[chk_addr_reg] ? rd_data : '0;

    // blocks of this word that may be handed out
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            allowed[b] = ((int'(chk_addr_reg) * WORD_BITS + b) >= int'(fdb_reg))
                      && ((int'(chk_addr_reg) * WORD_BITS + b) < NUM_BLOCKS);
        end
    end

    assign free_vec = ~eff_word & allowed;
    assign hit      = (free_vec != '0);
    assign hit_pos  = lowest_one(free_vec);
    assign hit_bit  = word_t'(1) << hit_pos;
    assign free_bit = word_t'(1) << idx_bit_reg;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        chk_addr_next = chk_addr_reg;
        idx_bit_next  = idx_bit_reg;
        res_num_next  = res_num_reg;
        res_st_next   = res_st_reg;
        rd_addr       = WORD_AW'(chk_addr_reg + 1'b1);
        ram_we        = 1'b0;
        ram_wdata     = eff_word;
        case (state_reg)
            S_IDLE:
            begin
                if (op == OP_ALLOC)
                begin
                    rd_addr = WORD_AW'(fdb_reg / WORD_BITS);
                end
                else
                begin
                    rd_addr = WORD_AW'(block_index / WORD_BITS);
                end
                if (accept)
                begin
                    res_num_next = '0;
                    if (op == OP_ALLOC)
                    begin
                        chk_addr_next = WORD_AW'(fdb_reg / WORD_BITS);
                        if (fdb_beyond)
                        begin
                            res_st_next = ST_OUT_OF_BLOCKS;
                            state_next  = S_PUB;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        chk_addr_next = WORD_AW'(block_index / WORD_BITS);
                        idx_bit_next  = BIT_W'(block_index % WORD_BITS);
                        if (idx_beyond)
                        begin
                            res_st_next = ST_OUT_OF_RANGE;
                            state_next  = S_PUB;
                        end
                        else
                        begin
                            state_next = S_FREE;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    ram_we       = 1'b1;
                    ram_wdata    = eff_word | hit_bit;
                    res_num_next = BLK_W'(int'(chk_addr_reg) * WORD_BITS + int'(hit_pos));
                    res_st_next  = ST_OK;
                    state_next   = S_PUB;
                end
                else if (32'(chk_addr_reg) == NUM_WORDS - 1)
                begin
                    res_st_next = ST_OUT_OF_BLOCKS;
                    state_next  = S_PUB;
                end
                else
                begin
                    chk_addr_next = WORD_AW'(chk_addr_reg + 1'b1);
                end
            end
            S_FREE:
            begin
                if ((eff_word & free_bit) == '0)
                begin
                    res_st_next = ST_DOUBLE_FREE;
                end
                else
                begin
                    ram_we      = 1'b1;
                    ram_wdata   = eff_word & ~free_bit;
                    res_st_next = ST_OK;
                end
                state_next = S_PUB;
            end
            S_PUB:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fdb_reg       <= FDB_RESET;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                fdb_reg <= cfg_wdata;
            end
            if (ram_we)
            begin
                valid_reg[chk_addr_reg] <= 1'b1;
            end
            if (state_reg == S_PUB && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        chk_addr_reg <= chk_addr_next;
        idx_bit_reg  <= idx_bit_next;
        res_num_reg  <= res_num_next;
        res_st_reg   <= res_st_next;
        if (state_reg == S_PUB && slot_free)
        begin
            out_num_reg <= res_num_reg;
            out_st_reg  <= res_st_reg;
        end
    end

    // bitmap writes happen only at the end of a scan or a free
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_SCAN || state_reg == S_FREE))
        else $error("bitmap written outside scan or free");

    // an allocation claims a block that was free and allowed
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && hit) |-> ((eff_word & hit_bit) == '0
            && (allowed & hit_bit) != '0))
        else $error("allocation claimed a used or forbidden block");

    // a failed request never reports a block number
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_st_reg != ST_OK) |-> (out_num_reg == '0))
        else $error("nonzero block number on error status");

    // an accepted request always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // a result is only published into a free output slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_num_reg)
            && $stable(out_st_reg)))
        else $error("pending result overwritten");

endmodule
